FILE: rtl/smm_pkg.sv
// ============================================================================
// smm_pkg: shared definitions for the square matrix multiplier
// Sizes, widths, record types and helpers shared by the loader, the bank
// queue, the compute engine and the top level.
// ============================================================================
package smm_pkg;

  localparam int MATRIX_SIZE = 4;

  localparam int ELEMS       = MATRIX_SIZE * MATRIX_SIZE;
  localparam int IDX_W       = $clog2(ELEMS);
  localparam int ADDR_W      = IDX_W + 1;
  localparam int STORE_DEPTH = 2 ** ADDR_W;
  localparam int RC_W        = $clog2(MATRIX_SIZE);

  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 32;
  localparam int RESULT_W  = 34;
  localparam int OUT_IDX_W = 2;

  localparam int TOK_DEPTH   = 2;
  localparam int TOK_PTR_W   = $clog2(TOK_DEPTH);
  localparam int TOK_CNT_W   = $clog2(TOK_DEPTH + 1);
  localparam int OFIFO_DEPTH = 2;
  localparam int OF_PTR_W    = $clog2(OFIFO_DEPTH);
  localparam int OF_CNT_W    = $clog2(OFIFO_DEPTH + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMS - 1);
  localparam logic [IDX_W-1:0] ROW_STEP = IDX_W'(MATRIX_SIZE);
  localparam logic [RC_W-1:0]  LAST_RC  = RC_W'(MATRIX_SIZE - 1);

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [ELEM_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] left_addr;
    logic [ADDR_W-1:0] right_addr;
  } store_rd_t;

  typedef struct packed {
    logic push;
    logic bank;
  } tok_push_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic bank;
  } tok_stat_t;

  typedef struct packed {
    logic [RESULT_W-1:0]  value;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic                 last;
  } result_t;

  // Keeps the low bits of a row or column index for the result ports.
  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [RC_W-1:0] idx);
    logic [RC_W+OUT_IDX_W-1:0] ext;
    ext = {{OUT_IDX_W{1'b0}}, idx};
    return ext[OUT_IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/smm_ram.sv
// ============================================================================
// smm_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/smm_front.sv
// ============================================================================
// smm_front: element loader
// Counts incoming elements, steers them into the left or right store of the
// current bank and hands the bank to the compute side when B is complete.
// ============================================================================
module smm_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic signed [smm_pkg::ELEM_W-1:0] in_element_value,
  input  smm_pkg::tok_stat_t               tok_stat,
  output smm_pkg::store_wr_t               left_wr,
  output smm_pkg::store_wr_t               right_wr,
  output smm_pkg::tok_push_t               tok_push
);
  import smm_pkg::*;

  logic [IDX_W-1:0] idx_r;
  logic             sel_right_r;
  logic             bank_r;
  logic             accept;
  logic             idx_last;

  assign accept   = in_push && !tok_stat.full;
  assign idx_last = (idx_r == LAST_IDX);

  always_comb begin
    left_wr.we    = accept && !sel_right_r;
    left_wr.addr  = {bank_r, idx_r};
    left_wr.data  = in_element_value;
    right_wr.we   = accept && sel_right_r;
    right_wr.addr = {bank_r, idx_r};
    right_wr.data = in_element_value;
    tok_push.push = accept && sel_right_r && idx_last;
    tok_push.bank = bank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      sel_right_r <= 1'b0;
      bank_r      <= 1'b0;
    end else if (accept) begin
      if (idx_last) begin
        idx_r <= '0;
        // Finishing B hands this bank over and moves loading to the other one.
        if (sel_right_r) begin
          bank_r <= !bank_r;
        end
        sel_right_r <= !sel_right_r;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/smm_queue.sv
// ============================================================================
// smm_queue: bank hand-off queue
// Holds the banks that are loaded and not yet released by the compute side.
// ============================================================================
module smm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  smm_pkg::tok_push_t tok_push,
  input  logic               tok_pop,
  output smm_pkg::tok_stat_t tok_stat
);
  import smm_pkg::*;

  logic                 bank_q_r [TOK_DEPTH];
  logic [TOK_PTR_W-1:0] wr_ptr_r;
  logic [TOK_PTR_W-1:0] rd_ptr_r;
  logic [TOK_CNT_W-1:0] cnt_r;

  always_comb begin
    tok_stat.empty = (cnt_r == '0);
    tok_stat.full  = (cnt_r == TOK_CNT_W'(TOK_DEPTH));
    tok_stat.bank  = bank_q_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (tok_push.push) begin
      bank_q_r[wr_ptr_r] <= tok_push.bank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (tok_push.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (tok_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (tok_push.push && !tok_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!tok_push.push && tok_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/smm_back.sv
// ============================================================================
// smm_back: multiply-accumulate engine
// Walks the product matrix in row-major order, reads one pair of operands
// per cycle from the stores while a dot product runs and accumulates each
// dot product, then queues the result for the output side.
// ============================================================================
module smm_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  smm_pkg::tok_stat_t                 tok_stat,
  output logic                               tok_pop,
  output smm_pkg::store_rd_t                 store_rd,
  input  logic signed [smm_pkg::ELEM_W-1:0]  left_rdata,
  input  logic signed [smm_pkg::ELEM_W-1:0]  right_rdata,
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic signed [smm_pkg::RESULT_W-1:0] out_product_value,
  output logic [smm_pkg::OUT_IDX_W-1:0]      out_row_index,
  output logic [smm_pkg::OUT_IDX_W-1:0]      out_column_index,
  output logic                               out_last_result
);
  import smm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_RUN,
    S_WAIT
  } state_t;

  state_t           state_r;
  logic             bank_r;
  logic [RC_W-1:0]  row_r;
  logic [RC_W-1:0]  col_r;
  logic [RC_W-1:0]  k_r;
  logic [IDX_W-1:0] row_base_r;
  logic [IDX_W-1:0] a_idx_r;
  logic [IDX_W-1:0] b_idx_r;

  logic                     rd_vld_r;
  logic                     rd_first_r;
  logic                     rd_last_r;
  logic                     prod_vld_r;
  logic                     prod_first_r;
  logic                     prod_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [RESULT_W-1:0]      acc_r;
  logic [RESULT_W-1:0]      sum_nxt;

  result_t             ofifo_r [OFIFO_DEPTH];
  logic [OF_PTR_W-1:0] of_wr_ptr_r;
  logic [OF_PTR_W-1:0] of_rd_ptr_r;
  logic [OF_CNT_W-1:0] of_cnt_r;
  result_t             res;

  logic iss_first;
  logic iss_last;
  logic done;
  logic mat_last;
  logic of_pop;
  logic of_room;

  assign iss_first = (k_r == '0);
  assign iss_last  = (k_r == LAST_RC);
  assign mat_last  = (row_r == LAST_RC) && (col_r == LAST_RC);
  assign done      = prod_vld_r && prod_last_r;
  assign tok_pop   = (state_r == S_WAIT) && done && mat_last;
  assign of_pop    = out_pop && !out_empty;
  assign of_room   = (of_cnt_r != OF_CNT_W'(OFIFO_DEPTH));

  always_comb begin
    store_rd.re         = (state_r == S_RUN);
    store_rd.left_addr  = {bank_r, a_idx_r};
    store_rd.right_addr = {bank_r, b_idx_r};
  end

  // Sequencer: one dot product in flight at a time, started only when the
  // output queue has a free slot for its result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      bank_r     <= 1'b0;
      row_r      <= '0;
      col_r      <= '0;
      k_r        <= '0;
      row_base_r <= '0;
      a_idx_r    <= '0;
      b_idx_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!tok_stat.empty) begin
            bank_r     <= tok_stat.bank;
            row_r      <= '0;
            col_r      <= '0;
            row_base_r <= '0;
            state_r    <= S_START;
          end
        end
        S_START: begin
          if (of_room) begin
            a_idx_r <= row_base_r;
            b_idx_r <= IDX_W'(col_r);
            k_r     <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          a_idx_r <= a_idx_r + 1'b1;
          b_idx_r <= b_idx_r + ROW_STEP;
          k_r     <= k_r + 1'b1;
          if (iss_last) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (done) begin
            if (mat_last) begin
              state_r <= S_IDLE;
            end else begin
              if (col_r == LAST_RC) begin
                col_r      <= '0;
                row_r      <= row_r + 1'b1;
                row_base_r <= row_base_r + ROW_STEP;
              end else begin
                col_r <= col_r + 1'b1;
              end
              state_r <= S_START;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= store_rd.re;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r   <= iss_first;
    rd_last_r    <= iss_last;
    prod_first_r <= rd_first_r;
    prod_last_r  <= rd_last_r;
    prod_r       <= left_rdata * right_rdata;
  end

  // The sum wraps at the result width, matching the truncated output.
  assign sum_nxt = (prod_first_r ? '0 : acc_r)
                 + {{(RESULT_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (prod_vld_r) begin
      acc_r <= sum_nxt;
    end
  end

  always_comb begin
    res.value = sum_nxt;
    res.row   = to_out_idx(row_r);
    res.col   = to_out_idx(col_r);
    res.last  = mat_last;
  end

  always_ff @(posedge clk) begin
    if (done) begin
      ofifo_r[of_wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_ptr_r <= '0;
      of_rd_ptr_r <= '0;
      of_cnt_r    <= '0;
    end else begin
      if (done) begin
        of_wr_ptr_r <= of_wr_ptr_r + 1'b1;
      end
      if (of_pop) begin
        of_rd_ptr_r <= of_rd_ptr_r + 1'b1;
      end
      if (done && !of_pop) begin
        of_cnt_r <= of_cnt_r + 1'b1;
      end else if (!done && of_pop) begin
        of_cnt_r <= of_cnt_r - 1'b1;
      end
    end
  end

  assign out_empty         = (of_cnt_r == '0);
  assign out_product_value = ofifo_r[of_rd_ptr_r].value;
  assign out_row_index     = ofifo_r[of_rd_ptr_r].row;
  assign out_column_index  = ofifo_r[of_rd_ptr_r].col;
  assign out_last_result   = ofifo_r[of_rd_ptr_r].last;

endmodule

FILE: rtl/square_matrix_multiply_unit.sv
// ============================================================================
// square_matrix_multiply_unit: N by N matrix product
// Takes A then B, one element per request, and returns C = A * B in
// row-major order as exact Q18.16 sums.
// ============================================================================
// Usage: push 2*N*N signed Q8.8 elements, all of A in row-major order and
// then all of B; after the last element of B the N*N elements of C come out
// in row-major order, the final one with out_last_result set. Elements load
// at one per cycle while in_full is low. The stores are double banked, so a
// second pair of matrices can be loaded while the first is being multiplied;
// in_full rises only when both banks hold pairs not yet finished. A single
// multiply-accumulate unit fed by one read port per store produces the
// results: each element of C takes N operand reads, which pass the RAM read
// register and the multiplier register into the accumulator, and the next
// element starts only once its result is queued.
module square_matrix_multiply_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic signed [smm_pkg::ELEM_W-1:0]  in_element_value,
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic signed [smm_pkg::RESULT_W-1:0] out_product_value,
  output logic [smm_pkg::OUT_IDX_W-1:0]      out_row_index,
  output logic [smm_pkg::OUT_IDX_W-1:0]      out_column_index,
  output logic                               out_last_result
);
  import smm_pkg::*;

  store_wr_t   left_wr;
  store_wr_t   right_wr;
  store_rd_t   store_rd;
  tok_push_t   tok_push;
  tok_stat_t   tok_stat;
  logic        tok_pop;
  logic [ELEM_W-1:0] left_rdata;
  logic [ELEM_W-1:0] right_rdata;

  assign in_full = tok_stat.full;

  smm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_element_value (in_element_value),
    .tok_stat         (tok_stat),
    .left_wr          (left_wr),
    .right_wr         (right_wr),
    .tok_push         (tok_push)
  );

  smm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_push (tok_push),
    .tok_pop  (tok_pop),
    .tok_stat (tok_stat)
  );

  smm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_left_store (
    .clk   (clk),
    .we    (left_wr.we),
    .waddr (left_wr.addr),
    .wdata (left_wr.data),
    .re    (store_rd.re),
    .raddr (store_rd.left_addr),
    .rdata (left_rdata)
  );

  smm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_right_store (
    .clk   (clk),
    .we    (right_wr.we),
    .waddr (right_wr.addr),
    .wdata (right_wr.data),
    .re    (store_rd.re),
    .raddr (store_rd.right_addr),
    .rdata (right_rdata)
  );

  smm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .tok_stat          (tok_stat),
    .tok_pop           (tok_pop),
    .store_rd          (store_rd),
    .left_rdata        (left_rdata),
    .right_rdata       (right_rdata),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_product_value (out_product_value),
    .out_row_index     (out_row_index),
    .out_column_index  (out_column_index),
    .out_last_result   (out_last_result)
  );

endmodule

FILE: rtl/smm_checker.sv
// ============================================================================
// smm_port_checker: port-level checks for the matrix multiplier
// Watches the request and result ports of the top level over time.
// ============================================================================
module smm_port_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_push,
  input logic                               in_full,
  input logic signed [smm_pkg::ELEM_W-1:0]  in_element_value,
  input logic                               out_pop,
  input logic                               out_empty,
  input logic signed [smm_pkg::RESULT_W-1:0] out_product_value,
  input logic [smm_pkg::OUT_IDX_W-1:0]      out_row_index,
  input logic [smm_pkg::OUT_IDX_W-1:0]      out_column_index,
  input logic                               out_last_result
);
  import smm_pkg::*;

  // A result that is not taken stays on the ports unchanged.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_product_value)
      && $stable(out_row_index) && $stable(out_column_index)
      && $stable(out_last_result))
    else $error("waiting result changed before it was taken");

  // The final result of a matrix sits in its bottom right corner.
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_last_result |->
      out_row_index == OUT_IDX_W'(MATRIX_SIZE - 1)
      && out_column_index == OUT_IDX_W'(MATRIX_SIZE - 1))
    else $error("last result flagged away from the final element");

  // Both banks fill up only as the result of an accepted request.
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("input side became full without an accepted request");

  // A bank is released only as the last result of its matrix is queued, so
  // the output side cannot be empty when room opens on the input side.
  a_release_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_full) |-> !out_empty)
    else $error("input side freed up without a queued result");

endmodule

bind square_matrix_multiply_unit smm_port_checker u_smm_checker (.*);

FILE: sim/smm_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// smm_checker: product prediction and comparison for the matrix multiplier
// Watches both queue channels, mirrors the A and B loads, works out every
// element of C when a pair completes and compares each popped result with
// the oldest predicted element, field by field.
// ============================================================================
module smm_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic                                in_full,
  input  logic signed [smm_pkg::ELEM_W-1:0]   in_element_value,
  input  logic                                out_pop,
  input  logic                                out_empty,
  input  logic signed [smm_pkg::RESULT_W-1:0] out_product_value,
  input  logic [smm_pkg::OUT_IDX_W-1:0]       out_row_index,
  input  logic [smm_pkg::OUT_IDX_W-1:0]       out_column_index,
  input  logic                                out_last_result,
  output int                                  mismatch_count,
  output int                                  products_pending,
  output int                                  products_checked
);
  import smm_pkg::*;

  localparam int N = MATRIX_SIZE;
  localparam int MAX_REPORTS = 10;

  logic signed [ELEM_W-1:0] left_elems  [ELEMS];
  logic signed [ELEM_W-1:0] right_elems [ELEMS];
  int      elems_loaded;
  result_t expected_products [$];
  result_t oldest_product;
  int      row, col;

  // Exact sum of N Q8.8 products, kept to the low bits of the result port.
  function automatic result_t product_element(input int prow, input int pcol);
    logic signed [63:0] acc;
    logic signed [63:0] lhs;
    logic signed [63:0] rhs;
    result_t            elem;
    int                 k;
    acc = '0;
    for (k = 0; k < N; k++) begin
      lhs = left_elems[prow * N + k];
      rhs = right_elems[k * N + pcol];
      acc = acc + lhs * rhs;
    end
    elem.value = acc[RESULT_W-1:0];
    elem.row   = OUT_IDX_W'(prow);
    elem.col   = OUT_IDX_W'(pcol);
    elem.last  = (prow == N - 1) && (pcol == N - 1);
    return elem;
  endfunction

  initial begin
    mismatch_count   = 0;
    products_pending = 0;
    products_checked = 0;
    elems_loaded     = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      elems_loaded = 0;
      expected_products.delete();
    end else begin
      if (in_push && !in_full) begin
        if (elems_loaded < ELEMS) begin
          left_elems[elems_loaded] = in_element_value;
        end else begin
          right_elems[elems_loaded - ELEMS] = in_element_value;
        end
        elems_loaded++;
        // The request that completes B releases the whole product matrix.
        if (elems_loaded == 2 * ELEMS) begin
          elems_loaded = 0;
          for (row = 0; row < N; row++) begin
            for (col = 0; col < N; col++) begin
              expected_products.push_back(product_element(row, col));
            end
          end
        end
      end

      if (out_pop && !out_empty) begin
        products_checked++;
        if (expected_products.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: unexpected product %0d (row %0d col %0d last %0b)", $realtime,
                     out_product_value, out_row_index, out_column_index, out_last_result);
          end
        end else begin
          oldest_product = expected_products.pop_front();
          if (oldest_product.value !== out_product_value ||
              oldest_product.row !== out_row_index ||
              oldest_product.col !== out_column_index ||
              oldest_product.last !== out_last_result) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: product mismatch: expected %0d (row %0d col %0d last %0b)",
                       $realtime, $signed(oldest_product.value), oldest_product.row,
                       oldest_product.col, oldest_product.last);
              $display("%0t:                   got %0d (row %0d col %0d last %0b)",
                       $realtime, out_product_value, out_row_index, out_column_index,
                       out_last_result);
            end
          end
        end
      end
    end
    products_pending = expected_products.size();
  end

endmodule

FILE: sim/tb_square_matrix_multiply_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_square_matrix_multiply_unit: regression for the matrix multiplier
// Loads a directed pair of matrices built from the element extremes, then
// random pairs with varied value patterns, while both sides idle at random
// and the result side once holds off long enough to back up the input.
// ============================================================================
module tb_square_matrix_multiply_unit;
  import smm_pkg::*;

  localparam int N            = MATRIX_SIZE;
  localparam int RANDOM_PAIRS = 11;
  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 800;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = ELEMS * (N + 4) + 50;

  typedef enum int {
    FILL_FULL_RANGE = 0,
    FILL_EXTREMES   = 1,
    FILL_SMALL      = 2,
    FILL_MIXED      = 3
  } fill_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic signed [ELEM_W-1:0]   in_element_value;
  logic out_pop;
  logic out_empty;
  logic signed [RESULT_W-1:0] out_product_value;
  logic [OUT_IDX_W-1:0]       out_row_index;
  logic [OUT_IDX_W-1:0]       out_column_index;
  logic out_last_result;

  int mismatch_count;
  int products_pending;
  int products_checked;
  int quiet_cycles = 0;
  int full_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  square_matrix_multiply_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_element_value  (in_element_value),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_product_value (out_product_value),
    .out_row_index     (out_row_index),
    .out_column_index  (out_column_index),
    .out_last_result   (out_last_result)
  );

  smm_checker u_product_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_element_value  (in_element_value),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_product_value (out_product_value),
    .out_row_index     (out_row_index),
    .out_column_index  (out_column_index),
    .out_last_result   (out_last_result),
    .mismatch_count    (mismatch_count),
    .products_pending  (products_pending),
    .products_checked  (products_checked)
  );

  // Called at a falling edge; returns at the falling edge after the request
  // is taken, leaving push high so back-to-back elements need no gap.
  task automatic push_element(input logic signed [ELEM_W-1:0] elem, input int gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push          <= 1'b1;
    in_element_value <= elem;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (in_push && in_full) begin
      full_cycles <= full_cycles + 1;
    end
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: random pops, with quiet stretches and one long hold-off.
  initial begin : result_drain
    int   popped;
    int   wait_cycles;
    logic no_idle;
    logic held;
    popped  = 0;
    no_idle = 1'b0;
    held    = 1'b0;
    out_pop = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (popped % 16 == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      wait_cycles = no_idle ? 0 : $urandom_range(0, 12);
      if (!held && popped == HOLD_AFTER) begin
        held        = 1'b1;
        wait_cycles = HOLD_CYCLES;
      end
      if (wait_cycles > 0) begin
        out_pop <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      popped++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int                       i;
    int                       r;
    int                       c;
    int                       pair;
    int                       pick;
    logic                     burst;
    fill_mode_t               fill;
    fill_mode_t               element_fill;
    logic signed [ELEM_W-1:0] v;

    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_element_value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pair: row 0 of A and column 0 of B at the most negative
    // element give the largest sum, against column 1 at the most positive
    // the smallest; the rest mix extreme, unit and zero values.
    for (i = 0; i < ELEMS; i++) begin
      r = i / N;
      c = i % N;
      case (r)
        0: v = 16'sh8000;
        1: v = 16'sh7fff;
        2: begin
          case (c % 4)
            0: v = 16'sh0000;
            1: v = 16'sh0001;
            2: v = -16'sh0001;
            default: v = 16'sh0100;
          endcase
        end
        default: v = (c == r) ? 16'sh0100 : 16'sh0000;
      endcase
      push_element(v, $urandom_range(0, 12));
    end
    for (i = 0; i < ELEMS; i++) begin
      r = i / N;
      c = i % N;
      case (c)
        0: v = 16'sh8000;
        1: v = 16'sh7fff;
        2: v = (r % 2 == 1) ? -16'sh0001 : 16'sh0001;
        default: v = (c == r) ? 16'sh0100 : 16'sh0000;
      endcase
      push_element(v, 0);
    end

    for (pair = 0; pair < RANDOM_PAIRS; pair++) begin
      pick  = $urandom_range(0, 5);
      fill  = (pick > 3) ? FILL_FULL_RANGE : fill_mode_t'(pick);
      burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < 2 * ELEMS; i++) begin
        element_fill = (fill == FILL_MIXED) ? fill_mode_t'($urandom_range(0, 2)) : fill;
        case (element_fill)
          FILL_EXTREMES: begin
            case ($urandom_range(0, 4))
              0: v = 16'sh8000;
              1: v = 16'sh7fff;
              2: v = -16'sh0001;
              3: v = 16'sh0000;
              default: v = 16'sh0001;
            endcase
          end
          FILL_SMALL: v = ELEM_W'(int'($urandom_range(0, 1023)) - 512);
          default: v = ELEM_W'($urandom_range(0, 65535));
        endcase
        push_element(v, burst ? 0 : $urandom_range(0, 12));
      end
    end
    in_push <= 1'b0;

    while (products_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d matrix pairs of size %0d (%0d elements) and %0d products,",
             RANDOM_PAIRS + 1, N, (RANDOM_PAIRS + 1) * 2 * ELEMS, products_checked);
    $display("with %0d cycles of input back-pressure and %0d mismatches.",
             full_cycles, mismatch_count);
    if (mismatch_count == 0 && products_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
